// File: rtl/cbws_pkg.sv
// Shared types and constants for the clipped box window sum block.
`default_nettype none
package cbws_pkg;
	localparam int DEF_MAX_ROWS   = 1024;
	localparam int DEF_MAX_COLS   = 1024;
	localparam int DEF_MAX_RADIUS = 7;

	localparam int SIZE_W   = 13;  // holds any frame size up to 4096 and any position
	localparam int REG_W    = 11;
	localparam int RAD_W    = 3;
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 24;
	localparam int POS_W    = 10;
	localparam int IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_COLS = 2'd1;
	localparam logic [IDX_W-1:0] REG_RADIUS     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_DRAIN,
		ST_OUT
	} seq_state_t;
endpackage
`default_nettype wire

// File: rtl/clipped_box_window_sum.sv
// Clipped box window sum over a raster-order frame, line store in one RAM.
//
// Samples enter in raster order and are written into a line store of
// 2*MAX_RADIUS+1 rows. Every center whose clipped window is complete by the
// transferred sample is then summed by reading the window from the store, one
// sample per cycle, over one synchronous RAM read port. Each result passes
// through the setup, read, drain and output states and is held while the output
// is stalled; an input that completes no center leaves the block idle, and an
// edge sample that completes n centers produces those n results in turn.
// Input is stalled while results of the previous sample are worked out.
// Configuration must be written only while the block is idle.
`default_nettype none
module clipped_box_window_sum #(
	parameter int MAX_ROWS   = cbws_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS   = cbws_pkg::DEF_MAX_COLS,
	parameter int MAX_RADIUS = cbws_pkg::DEF_MAX_RADIUS
) (
	input  wire  logic                                clk,
	input  wire  logic                                arst_n,
	input  wire  logic                                cfg_we,
	input  wire  logic [cbws_pkg::IDX_W-1:0]          cfg_index,
	input  wire  logic [cbws_pkg::REG_W-1:0]          cfg_data,
	input  wire  logic                                in_valid,
	output logic                                      in_stall,
	input  wire  logic signed [cbws_pkg::SAMPLE_W-1:0] sample,
	input  wire  logic                                frame_start,
	output logic                                      out_valid,
	input  wire  logic                                out_stall,
	output logic [cbws_pkg::POS_W-1:0]                center_row,
	output logic [cbws_pkg::POS_W-1:0]                center_col,
	output logic signed [cbws_pkg::SUM_W-1:0]         block_sum,
	output logic                                      last_of_run
);
	import cbws_pkg::*;

	localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
	localparam int SLOT_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
	localparam int DEPTH      = STORE_ROWS * MAX_COLS;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(STORE_ROWS - 1);

	// configuration
	logic [REG_W-1:0] frame_rows_q, frame_cols_q;
	logic [RAD_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= REG_W'(1024);
			frame_cols_q <= REG_W'(1024);
			radius_q     <= RAD_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_ROWS: frame_rows_q <= cfg_data;
				REG_FRAME_COLS: frame_cols_q <= cfg_data;
				REG_RADIUS:     radius_q     <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SIZE_W-1:0] rows, cols, rad;
	always_comb begin
		if (frame_rows_q == '0)                         rows = SIZE_W'(1);
		else if (SIZE_W'(frame_rows_q) > SIZE_W'(MAX_ROWS)) rows = SIZE_W'(MAX_ROWS);
		else                                            rows = SIZE_W'(frame_rows_q);
		if (frame_cols_q == '0)                         cols = SIZE_W'(1);
		else if (SIZE_W'(frame_cols_q) > SIZE_W'(MAX_COLS)) cols = SIZE_W'(MAX_COLS);
		else                                            cols = SIZE_W'(frame_cols_q);
		if (SIZE_W'(radius_q) > SIZE_W'(MAX_RADIUS))    rad = SIZE_W'(MAX_RADIUS);
		else                                            rad = SIZE_W'(radius_q);
	end

	// sequencer state
	seq_state_t state_q, state_d;
	logic [SIZE_W-1:0] in_row_q, in_col_q;
	logic [SLOT_W-1:0] in_slot_q;
	logic [SIZE_W-1:0] i_q;
	logic [SLOT_W-1:0] islot_q;
	logic [SIZE_W-1:0] rhi_q, clo_q, chi_q, r_q, c_q;
	logic [SIZE_W-1:0] c0_q, c1_q, r1_q, y_q, x_q;
	logic [SLOT_W-1:0] yslot_q;
	logic              rd_s1;
	logic signed [SUM_W-1:0] acc_q;
	logic              out_valid_q;

	logic accept, out_xfer;
	assign accept   = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// position and completed span of the incoming sample
	logic              restart, row_last, col_last, row_ok, col_ok;
	logic [SIZE_W-1:0] pi, pj, rlo, rhi, clo, chi;
	logic [SLOT_W-1:0] pslot;
	always_comb begin
		restart  = frame_start || (in_row_q >= rows) || (in_col_q >= cols);
		pi       = restart ? '0 : in_row_q;
		pj       = restart ? '0 : in_col_q;
		pslot    = restart ? '0 : in_slot_q;
		row_last = (pi + SIZE_W'(1) == rows);
		col_last = (pj + SIZE_W'(1) == cols);
		row_ok   = row_last || (pi >= rad);
		col_ok   = col_last || (pj >= rad);
		rlo      = (pi >= rad) ? pi - rad : '0;
		clo      = (pj >= rad) ? pj - rad : '0;
		rhi      = row_last ? pi : pi - rad;
		chi      = col_last ? pj : pj - rad;
	end

	// clipped window of the current center
	logic [SIZE_W-1:0] r0, r1, c0, c1, row_dist;
	logic [SLOT_W-1:0] d_slot, slot0;
	always_comb begin
		r0 = (r_q >= rad) ? r_q - rad : '0;
		r1 = (r_q + rad < rows) ? r_q + rad : rows - SIZE_W'(1);
		c0 = (c_q >= rad) ? c_q - rad : '0;
		c1 = (c_q + rad < cols) ? c_q + rad : cols - SIZE_W'(1);
		row_dist = i_q - r0;
		d_slot   = row_dist[SLOT_W-1:0];
		slot0  = (islot_q >= d_slot) ? islot_q - d_slot
		                             : SLOT_W'(STORE_ROWS) + islot_q - d_slot;
	end

	// line store
	logic signed [SAMPLE_W-1:0] store [DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_s1;
	logic [AW-1:0] wr_addr, rd_addr;
	assign wr_addr = AW'(pslot) * AW'(MAX_COLS) + AW'(pj);
	assign rd_addr = AW'(yslot_q) * AW'(MAX_COLS) + AW'(x_q);

	always_ff @(posedge clk) begin
		if (accept)
			store[wr_addr] <= sample;
		rdata_s1 <= store[rd_addr];
	end

	logic signed [SUM_W-1:0] rd_ext;
	assign rd_ext = SUM_W'(rdata_s1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && row_ok && col_ok) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_READ;
			ST_READ:  if (x_q == c1_q && y_q == r1_q) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_xfer)
					state_d = (r_q == rhi_q && c_q == chi_q) ? ST_IDLE : ST_SETUP;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= (state_q == ST_READ);
			if (accept) begin
				// advance the write position now; the sums use the latched copy
				if (col_last) begin
					in_col_q <= '0;
					if (row_last) begin
						in_row_q  <= '0;
						in_slot_q <= '0;
					end else begin
						in_row_q  <= pi + SIZE_W'(1);
						in_slot_q <= (pslot == SLOT_TOP) ? '0 : pslot + SLOT_W'(1);
					end
				end else begin
					in_row_q  <= pi;
					in_col_q  <= pj + SIZE_W'(1);
					in_slot_q <= pslot;
				end
			end
			if (state_q == ST_DRAIN)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				i_q     <= pi;
				islot_q <= pslot;
				rhi_q   <= rhi;
				clo_q   <= clo;
				chi_q   <= chi;
				r_q     <= rlo;
				c_q     <= clo;
			end
			ST_SETUP: begin
				y_q     <= r0;
				x_q     <= c0;
				r1_q    <= r1;
				c0_q    <= c0;
				c1_q    <= c1;
				yslot_q <= slot0;
				acc_q   <= '0;
			end
			ST_READ: begin
				if (x_q == c1_q) begin
					x_q     <= c0_q;
					y_q     <= y_q + SIZE_W'(1);
					yslot_q <= (yslot_q == SLOT_TOP) ? '0 : yslot_q + SLOT_W'(1);
				end else begin
					x_q <= x_q + SIZE_W'(1);
				end
				if (rd_s1)
					acc_q <= acc_q + rd_ext;
			end
			ST_DRAIN: begin
				block_sum   <= acc_q + rd_ext;
				center_row  <= r_q[POS_W-1:0];
				center_col  <= c_q[POS_W-1:0];
				last_of_run <= (r_q == rhi_q) && (c_q == chi_q);
			end
			ST_OUT: begin
				if (out_xfer) begin
					if (c_q == chi_q) begin
						c_q <= clo_q;
						r_q <= r_q + SIZE_W'(1);
					end else begin
						c_q <= c_q + SIZE_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	ap_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !out_valid_q)
		else $error("result pending while idle");
	ap_drain_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (out_valid_q && state_q == ST_OUT))
		else $error("drained sum not presented");
	ap_read_data_used: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (state_q == ST_READ || state_q == ST_DRAIN))
		else $error("read data returned outside summing");
	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> in_stall)
		else $error("input accepted while result pending");
endmodule
`default_nettype wire
